>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Clocked implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/tldm_pkg.sv
// Shared constants, types and command/status structs for the thruster lag core.
// No dependencies.
package tldm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [17:0] QUANT_LIMIT = 18'd32112;
  localparam logic [39:0] FUEL_MAX = 40'hFF_FFFF_FFFF;

  // Register indexes
  localparam logic [2:0] REG_DELAY = 3'd0;
  localparam logic [2:0] REG_AON = 3'd1;
  localparam logic [2:0] REG_AOFF = 3'd2;
  localparam logic [2:0] REG_MAXT = 3'd3;
  localparam logic [2:0] REG_FLOW = 3'd4;
  localparam logic [2:0] REG_FUELT = 3'd5;
  localparam logic [2:0] REG_FUEL0 = 3'd6;

  // Queue entry: {time, cmd}
  typedef struct packed {
    logic [31:0] time_stamp;
    logic        cmd;
  } qentry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input item
    logic cmd_item;  // process command (queue write)
    logic tick_inc;  // advance tick counter
    logic pop;       // pop head entry if due
    logic lag;       // compute lag step
    logic fuel;      // update fuel and outputs
    logic emit;      // load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_cmd;
    logic head_due;
  } dp_sts_t;

endpackage

>>> rtl/core/tldm_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module tldm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/tldm_ctrl.sv
// Controller state machine sequencing command and tick items.
// Depends on tldm_pkg.
module tldm_ctrl import tldm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_LAG  = 3'd3;
  localparam logic [2:0] S_FUEL = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  // Next state and command decode
  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_cmd) begin
          cmd.cmd_item = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.tick_inc = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_POP;  // head read settles
      S_POP: begin
        if (sts.head_due) begin
          cmd.pop   = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_LAG;
        end
      end
      S_LAG: begin
        cmd.lag   = 1'b1;
        state_nxt = S_FUEL;
      end
      S_FUEL: begin
        cmd.fuel  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ovalid_r || out_ready) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

>>> rtl/core/tldm_dp.sv
// Datapath: quantizer, delay queue, lag step, fuel integration, output register.
// Depends on tldm_pkg and tldm_ram.
module tldm_dp import tldm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic         in_func,
  input  logic [17:0]  in_command_fraction,
  input  logic [15:0]  delay_ticks,
  input  logic [16:0]  alpha_on,
  input  logic [16:0]  alpha_off,
  input  logic [15:0]  max_thrust,
  input  logic [23:0]  flow_at_full,
  input  logic [23:0]  fuel_per_tick_full,
  input  logic [31:0]  initial_fuel,
  output logic [15:0]  out_thrust,
  output logic [23:0]  out_mass_flow,
  output logic [31:0]  out_fuel_remaining,
  output logic         out_fuel_empty,
  output logic [16:0]  out_thrust_level,
  output logic         out_applied_command,
  output logic         out_command_bit,
  output logic         out_command_invalid,
  output logic         out_queue_full
);
  logic        func_r;
  logic [17:0] frac_r;
  logic [31:0] tick_r;
  logic [QW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic        delayed_r;
  logic [16:0] level_r;
  logic [39:0] fuel_used_r;
  // time stamp of the last pushed entry kept in flops for the same-tick overwrite
  logic [31:0] last_time_r;
  logic        bit_r, inval_r, full_r;

  logic        qwe;
  logic [QW-1:0] qwaddr;
  qentry_t     qwdata, qrdata;

  tldm_ram #(.WIDTH(33), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata),
    .raddr(head_r), .rdata(qrdata)
  );

  // Quantizer
  logic        q_bit, q_inval;
  logic signed [17:0] sfrac;
  always_comb begin
    sfrac   = $signed(frac_r);
    q_bit   = 1'b0;
    q_inval = 1'b0;
    if (sfrac == 18'sd0) begin
      q_bit = 1'b0;
    end else if (frac_r == {1'b0, ONE_Q16}) begin
      q_bit = 1'b1;
    end else if (sfrac > 18'sd0 && frac_r <= QUANT_LIMIT) begin
      q_bit = 1'b0;
    end else if (sfrac > 18'sd0 && frac_r < {1'b0, ONE_Q16}) begin
      q_bit = 1'b1;
    end else begin
      q_inval = 1'b1;
    end
  end

  // Queue write decision
  logic same_tick, qfull;
  logic [QW-1:0] tail_prev, tail_next, head_next;
  assign same_tick = (count_r != '0) && (last_time_r == tick_r);
  assign qfull     = (count_r == CW'(QUEUE_DEPTH));
  assign tail_prev = (tail_r == '0) ? QW'(QUEUE_DEPTH - 1) : tail_r - 1'b1;
  assign tail_next = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_next = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    qwe    = 1'b0;
    qwaddr = tail_r;
    qwdata = '{time_stamp: tick_r, cmd: q_bit};
    if (cmd.cmd_item) begin
      if (same_tick) begin
        qwe    = 1'b1;
        qwaddr = tail_prev;
      end else if (!qfull) begin
        qwe = 1'b1;
      end
    end
  end

  // Due test on the registered head entry
  logic [31:0] age;
  assign age          = tick_r - qrdata.time_stamp;
  assign sts.head_due = (count_r != '0) && (age >= {16'd0, delay_ticks});
  assign sts.is_cmd   = func_r;

  // Lag step: one 17x17 multiply
  logic [16:0] alpha, diff;
  logic [33:0] prod;
  logic [17:0] step_w;
  logic [16:0] step, lvl_new;
  always_comb begin
    alpha = delayed_r ? alpha_on : alpha_off;
    if (alpha > ONE_Q16) alpha = ONE_Q16;
    diff   = delayed_r ? (ONE_Q16 - level_r) : level_r;
    prod   = 34'(diff) * 34'(alpha) + 34'd32768;
    step_w = prod[33:16];
    step   = (step_w > {1'b0, diff}) ? diff : step_w[16:0];
    lvl_new = delayed_r ? level_r + step : level_r - step;
    if (lvl_new > ONE_Q16) lvl_new = ONE_Q16;
  end

  // Fuel integration: one 17x24 multiply
  logic [40:0] use_p;
  logic [39:0] use_v, room;
  assign use_p = 41'(level_r) * 41'(fuel_per_tick_full);
  assign use_v = {16'd0, use_p[39:16]};
  assign room  = FUEL_MAX - fuel_used_r;

  // Output products
  logic [32:0] thr_p;
  logic [40:0] flow_p;
  assign thr_p  = 33'(level_r) * 33'(max_thrust);
  assign flow_p = 41'(level_r) * 41'(flow_at_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      delayed_r   <= 1'b0;
      level_r     <= '0;
      fuel_used_r <= '0;
    end else begin
      if (cmd.cmd_item && !same_tick && !qfull) begin
        tail_r  <= tail_next;
        count_r <= count_r + 1'b1;
      end
      if (cmd.tick_inc) tick_r <= tick_r + 32'd1;
      if (cmd.pop) begin
        delayed_r <= qrdata.cmd;
        head_r    <= head_next;
        count_r   <= count_r - 1'b1;
      end
      if (cmd.lag) level_r <= lvl_new;
      if (cmd.fuel) fuel_used_r <= (room < use_v) ? FUEL_MAX : fuel_used_r + use_v;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      frac_r <= in_command_fraction;
    end
    if (cmd.cmd_item && !same_tick && !qfull) last_time_r <= tick_r;
    if (cmd.cmd_item) begin
      bit_r   <= q_bit;
      inval_r <= q_inval;
      full_r  <= !same_tick && qfull;
    end else if (cmd.tick_inc) begin
      bit_r   <= 1'b0;
      inval_r <= 1'b0;
      full_r  <= 1'b0;
    end
    if (cmd.emit) begin
      out_thrust          <= thr_p[31:16];
      out_mass_flow       <= flow_p[39:16];
      out_fuel_remaining  <= (fuel_used_r < {8'd0, initial_fuel}) ?
                             initial_fuel - fuel_used_r[31:0] : 32'd0;
      out_fuel_empty      <= (fuel_used_r >= {8'd0, initial_fuel});
      out_thrust_level    <= level_r;
      out_applied_command <= delayed_r;
      out_command_bit     <= bit_r;
      out_command_invalid <= inval_r;
      out_queue_full      <= full_r;
    end
  end
endmodule

>>> rtl/core/thruster_lag_delay_model_core.sv
// Thruster lag with transport delay: top level, registers and APB port.
// Depends on tldm_pkg, tldm_ctrl, tldm_dp.
// Command item: decoded, queued, then emitted. Tick item: tick count advances,
// each due queued command pops after a queue RAM read wait, then lag, fuel, emit.
// One item at a time. rst_n is synchronous: control, config regs to defaults.
module thruster_lag_delay_model_core import tldm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [17:0] in_command_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_thrust,
  output logic [23:0] out_mass_flow,
  output logic [31:0] out_fuel_remaining,
  output logic        out_fuel_empty,
  output logic [16:0] out_thrust_level,
  output logic        out_applied_command,
  output logic        out_command_bit,
  output logic        out_command_invalid,
  output logic        out_queue_full,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] delay_r, maxt_r;
  logic [16:0] aon_r, aoff_r;
  logic [23:0] flow_r, fuelt_r;
  logic [31:0] fuel0_r;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      aon_r   <= ONE_Q16;
      aoff_r  <= ONE_Q16;
      maxt_r  <= '0;
      flow_r  <= '0;
      fuelt_r <= '0;
      fuel0_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_DELAY: delay_r <= pwdata[15:0];
        REG_AON:   aon_r   <= pwdata[16:0];
        REG_AOFF:  aoff_r  <= pwdata[16:0];
        REG_MAXT:  maxt_r  <= pwdata[15:0];
        REG_FLOW:  flow_r  <= pwdata[23:0];
        REG_FUELT: fuelt_r <= pwdata[23:0];
        REG_FUEL0: fuel0_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (ridx)
      REG_DELAY: prdata = {16'd0, delay_r};
      REG_AON:   prdata = {15'd0, aon_r};
      REG_AOFF:  prdata = {15'd0, aoff_r};
      REG_MAXT:  prdata = {16'd0, maxt_r};
      REG_FLOW:  prdata = {8'd0, flow_r};
      REG_FUELT: prdata = {8'd0, fuelt_r};
      REG_FUEL0: prdata = fuel0_r;
      default:   prdata = '0;
    endcase
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  tldm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  tldm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_func), .in_command_fraction(in_command_fraction),
    .delay_ticks(delay_r), .alpha_on(aon_r), .alpha_off(aoff_r),
    .max_thrust(maxt_r), .flow_at_full(flow_r), .fuel_per_tick_full(fuelt_r),
    .initial_fuel(fuel0_r),
    .out_thrust(out_thrust), .out_mass_flow(out_mass_flow),
    .out_fuel_remaining(out_fuel_remaining), .out_fuel_empty(out_fuel_empty),
    .out_thrust_level(out_thrust_level), .out_applied_command(out_applied_command),
    .out_command_bit(out_command_bit), .out_command_invalid(out_command_invalid),
    .out_queue_full(out_queue_full)
  );
endmodule

>>> rtl/core/tldm_checker.sv
// Port-level checker for the thruster lag core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tldm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_thrust_level,
  input logic        out_fuel_empty,
  input logic [31:0] out_fuel_remaining,
  input logic        out_command_bit,
  input logic        out_command_invalid
);
  // Lag state never exceeds one
  `ASSERT_IMPL(a_level_max, clk, rst_n, out_valid, out_thrust_level <= 17'd65536)
  // Empty tank reports no fuel left
  `ASSERT_IMPL(a_empty, clk, rst_n, out_valid && out_fuel_empty, out_fuel_remaining == 32'd0)
  // Invalid command quantizes to off
  `ASSERT_IMPL(a_inval, clk, rst_n, out_valid && out_command_invalid, !out_command_bit)
  // An accepted item is not followed by acceptance next cycle
  `ASSERT_NEXT(a_seq, clk, rst_n, in_valid && in_ready, !in_ready)
  // Stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind thruster_lag_delay_model_core tldm_checker u_chk (.*);
